FILE: design/swcrd_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor word response decoder.
// No dependencies; imported by every module of the block.
package swcrd_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [15:0] READY_MASK  = 16'h07FF;
   localparam logic [14:0] TEMP_GAIN   = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_GAIN    = 14'd10000;

   typedef enum logic [1:0] {
      KIND_READY  = 2'd0,
      KIND_MEAS   = 2'd1,
      KIND_SERIAL = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_HIGH = 2'd0,
      PH_LOW  = 2'd1,
      PH_CRC  = 2'd2
   } phase_type;

   // one finished response, handed from parser to decoder
   typedef struct packed {
      kind_type    kind;
      logic        crc_fail;
      logic [15:0] w0;
      logic [15:0] w1;
      logic [15:0] w2;
   } job_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
         else      c = {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: design/swcrd_front.sv
// Byte parser: tracks byte phase, runs the CRC-8, assembles words and emits one job
// per completed response. Depends on swcrd_pkg.
module swcrd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_first,
   input  logic              q_full,
   output logic              push,
   output swcrd_pkg::job_type job
);
   import swcrd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  widx_ff, widx_in;
   logic [7:0]  crc_ff, crc_in;
   logic        fail_ff, fail_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] word_ff [3];

   logic        accept;
   phase_type   phase_eff;
   logic [1:0]  widx_eff;
   logic [1:0]  wi;
   logic [1:0]  wi_next;
   logic [7:0]  crc_eff;
   logic [7:0]  crc_step;
   logic        fail_eff;
   logic        fail_word;
   kind_type    mode_kind;
   logic        last_word;
   logic        done;

   assign accept = req_valid & ~q_full;

   always_comb begin
      unique case (req_mode)
         KIND_MEAS:   mode_kind = KIND_MEAS;
         KIND_SERIAL: mode_kind = KIND_SERIAL;
         default:     mode_kind = KIND_READY;
      endcase
   end

   assign phase_eff = req_first ? PH_HIGH : phase_ff;
   assign widx_eff  = req_first ? 2'd0 : widx_ff;
   assign crc_eff   = req_first ? CRC_INIT : crc_ff;
   assign fail_eff  = req_first ? 1'b0 : fail_ff;
   assign kind_in   = (accept && req_first) ? mode_kind : kind_ff;
   assign wi        = (widx_eff > 2'd2) ? 2'd2 : widx_eff;
   assign wi_next   = wi + 2'd1;
   assign crc_step  = crc8_update(crc_eff, req_rx_byte);
   assign fail_word = fail_eff | (req_rx_byte != crc_eff);
   assign last_word = (kind_in == KIND_READY) ? (wi_next >= 2'd1) : (wi_next >= 2'd3);

   // next state
   always_comb begin
      phase_in = phase_ff;
      widx_in  = widx_ff;
      crc_in   = crc_ff;
      fail_in  = fail_ff;
      done     = 1'b0;
      if (accept) begin
         unique case (phase_eff)
            PH_HIGH: begin
               phase_in = PH_LOW;
               widx_in  = widx_eff;
               crc_in   = crc_step;
               fail_in  = fail_eff;
            end
            PH_LOW: begin
               phase_in = PH_CRC;
               widx_in  = widx_eff;
               crc_in   = crc_step;
               fail_in  = fail_eff;
            end
            default: begin
               phase_in = PH_HIGH;
               crc_in   = CRC_INIT;
               if (last_word) begin
                  done    = 1'b1;
                  widx_in = 2'd0;
                  fail_in = 1'b0;
               end else begin
                  widx_in = wi_next;
                  fail_in = fail_word;
               end
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      push         = done;
      job.kind     = kind_in;
      job.crc_fail = fail_word;
      job.w0       = word_ff[0];
      job.w1       = word_ff[1];
      job.w2       = word_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HIGH;
         widx_ff  <= 2'd0;
         crc_ff   <= CRC_INIT;
         fail_ff  <= 1'b0;
         kind_ff  <= KIND_READY;
      end else begin
         phase_ff <= phase_in;
         widx_ff  <= widx_in;
         crc_ff   <= crc_in;
         fail_ff  <= fail_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_eff == PH_HIGH) word_ff[wi][15:8] <= req_rx_byte;
      if (accept && phase_eff == PH_LOW)  word_ff[wi][7:0]  <= req_rx_byte;
   end

endmodule

FILE: design/swcrd_queue.sv
// Two-entry job queue between parser and decoder.
// Depends on swcrd_pkg for the job type.
module swcrd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swcrd_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output swcrd_pkg::job_type head
);
   import swcrd_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign wr_ptr_in = wr_ptr_ff ^ do_push;
   assign rd_ptr_in = rd_ptr_ff ^ do_pop;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 2'd1;
      else if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

FILE: design/swcrd_back.sv
// Decoder: scales measurement words through a product register and holds the
// result word in an output register. Depends on swcrd_pkg.
module swcrd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  swcrd_pkg::job_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic               rsp_status,
   output logic               rsp_data_ready,
   output logic [15:0]        rsp_co2_ppm,
   output logic signed [14:0] rsp_temp_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [47:0]        rsp_serial_number
);
   import swcrd_pkg::*;

   // product stage
   logic        p_vld_ff;
   job_type     p_job_ff;
   logic [30:0] t_prod_ff, t_prod_in;
   logic [29:0] h_prod_ff, h_prod_in;
   logic        p_adv;

   // output stage
   logic        o_vld_ff;
   logic [1:0]  o_kind_ff, o_kind_in;
   logic        o_status_ff, o_status_in;
   logic        o_ready_ff, o_ready_in;
   logic [15:0] o_co2_ff, o_co2_in;
   logic [14:0] o_temp_ff, o_temp_in;
   logic [13:0] o_hum_ff, o_hum_in;
   logic [47:0] o_serial_ff, o_serial_in;
   logic        o_load;

   assign o_load    = ~o_vld_ff | ~rsp_stall;
   assign p_adv     = o_load | ~p_vld_ff;
   assign q_pop     = p_adv & q_not_empty;
   assign t_prod_in = 31'(TEMP_GAIN) * 31'(q_head.w1);
   assign h_prod_in = 30'(HUM_GAIN) * 30'(q_head.w2);

   always_comb begin
      o_kind_in   = p_job_ff.kind;
      o_status_in = p_job_ff.crc_fail;
      o_ready_in  = 1'b0;
      o_co2_in    = '0;
      o_temp_in   = '0;
      o_hum_in    = '0;
      o_serial_in = '0;
      if (!p_job_ff.crc_fail) begin
         unique case (p_job_ff.kind)
            KIND_MEAS: begin
               o_co2_in  = p_job_ff.w0;
               o_temp_in = t_prod_ff[30:16] - TEMP_OFFSET;
               o_hum_in  = h_prod_ff[29:16];
            end
            KIND_SERIAL: o_serial_in = {p_job_ff.w0, p_job_ff.w1, p_job_ff.w2};
            default:     o_ready_in  = |(p_job_ff.w0 & READY_MASK);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (p_adv)  p_vld_ff <= q_not_empty;
         if (o_load) o_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_job_ff  <= q_head;
         t_prod_ff <= t_prod_in;
         h_prod_ff <= h_prod_in;
      end
      if (o_load && p_vld_ff) begin
         o_kind_ff   <= o_kind_in;
         o_status_ff <= o_status_in;
         o_ready_ff  <= o_ready_in;
         o_co2_ff    <= o_co2_in;
         o_temp_ff   <= o_temp_in;
         o_hum_ff    <= o_hum_in;
         o_serial_ff <= o_serial_in;
      end
   end

   assign rsp_valid          = o_vld_ff;
   assign rsp_kind           = o_kind_ff;
   assign rsp_status         = o_status_ff;
   assign rsp_data_ready     = o_ready_ff;
   assign rsp_co2_ppm        = o_co2_ff;
   assign rsp_temp_centi     = o_temp_ff;
   assign rsp_humidity_centi = o_hum_ff;
   assign rsp_serial_number  = o_serial_ff;

   a_err_clears_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_data_ready && rsp_co2_ppm == '0 &&
         rsp_temp_centi == '0 && rsp_humidity_centi == '0 && rsp_serial_number == '0))
      else $error("error word carries decoded fields");

   a_ready_kind_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_READY) |-> (rsp_co2_ppm == '0 &&
         rsp_humidity_centi == '0 && rsp_serial_number == '0))
      else $error("data-ready word carries foreign fields");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_MEAS) |-> (rsp_humidity_centi < 14'd10000))
      else $error("humidity out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (p_vld_ff && o_vld_ff && rsp_stall) |=> p_vld_ff)
      else $error("product stage lost a word under stall");

endmodule

FILE: design/sensor_word_crc_response_decoder_top.sv
// Sensor word response decoder, top level.
// Depends on swcrd_pkg, swcrd_front, swcrd_queue and swcrd_back.
//
// req_* carries one received byte per word with its response mode and a
// first-byte mark; rsp_* carries one decoded response per word. Both channels
// move a word at a clock edge where valid is high and stall is low.
// Responses are runs of 3-byte words (two data bytes and a CRC-8, poly 0x31,
// init 0xFF). On the CRC byte of the last word the parser queues a job; the
// result reaches rsp_* through the queue, then the product register, then the
// output register.
// Throughput: one byte per cycle while req_stall is low, set by the CRC step in the
// parser; a response needs at least three bytes, so the decoder never limits it.
// When the receiver stalls, the output and product registers hold and the
// two-entry queue fills; req_stall rises only when the queue is full.
// Synchronous reset clears the parser to a data-ready response at its first
// byte and empties the queue and both decoder stages.
module sensor_word_crc_response_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_first,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic               rsp_status,
   output logic               rsp_data_ready,
   output logic [15:0]        rsp_co2_ppm,
   output logic signed [14:0] rsp_temp_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [47:0]        rsp_serial_number
);
   import swcrd_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_not_empty;

   assign req_stall = q_full;

   swcrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .req_first   (req_first),
      .q_full      (q_full),
      .push        (push),
      .job         (push_job)
   );

   swcrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_job)
   );

   swcrd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (head_job),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_data_ready     (rsp_data_ready),
      .rsp_co2_ppm        (rsp_co2_ppm),
      .rsp_temp_centi     (rsp_temp_centi),
      .rsp_humidity_centi (rsp_humidity_centi),
      .rsp_serial_number  (rsp_serial_number)
   );

endmodule

FILE: tb/sv/sensor_word_crc_response_decoder_top_test.sv
// Testbench for sensor_word_crc_response_decoder_top: directed and random byte streams.
// Depends on swcrd_pkg for kinds, phases and CRC constants; predicts each decoded word
// in-bench and checks it field by field against the rsp_ channel.
module sensor_word_crc_response_decoder_top_test;
   import swcrd_pkg::*;

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         RANDOM_BYTES  = 1350;
   localparam int         MAX_WAIT      = 12;
   localparam int         DRAIN_CYCLES  = 32;
   localparam int         CYCLE_LIMIT   = 500000;

   typedef struct {
      kind_type           kind;
      logic               status;
      logic               ready;
      logic [15:0]        co2;
      logic signed [14:0] temp;
      logic [13:0]        hum;
      logic [47:0]        serial;
   } sensor_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode = 2'd0;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_first = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic               rsp_status;
   logic               rsp_data_ready;
   logic [15:0]        rsp_co2_ppm;
   logic signed [14:0] rsp_temp_centi;
   logic [13:0]        rsp_humidity_centi;
   logic [47:0]        rsp_serial_number;

   // parser state mirror
   phase_type   rx_phase = PH_HIGH;
   logic [1:0]  rx_word = 2'd0;
   logic [7:0]  rx_crc = CRC_INIT;
   logic [15:0] rx_words [3] = '{16'h0, 16'h0, 16'h0};
   logic        rx_fail = 1'b0;
   kind_type    rx_kind = KIND_READY;

   sensor_result_type awaited_results [$];
   int             mismatch_count = 0;
   int             bytes_sent = 0;
   int             send_quiet_left = 0;
   int             sink_quiet_left = 0;
   int             cycle_count = 0;

   sensor_word_crc_response_decoder_top uut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // serial form of CRC-8, poly 0x31
   function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc;
      for (int i = 7; i >= 0; i--)
         r = {r[6:0], 1'b0} ^ ((r[7] ^ data[i]) ? CRC_POLY : 8'h00);
      return r;
   endfunction

   function automatic logic [23:0] frame_word(input logic [15:0] w, input bit corrupt);
      logic [7:0] crc;
      crc = crc_next(crc_next(CRC_INIT, w[15:8]), w[7:0]);
      if (corrupt)
         crc = crc ^ 8'($urandom_range(1, 255));
      return {w, crc};
   endfunction

   function automatic bit decode_byte(input logic [1:0] mode, input logic [7:0] b,
                                      input logic first, output sensor_result_type r);
      int t;
      int h;
      r.kind   = KIND_READY;
      r.status = 1'b0;
      r.ready  = 1'b0;
      r.co2    = '0;
      r.temp   = '0;
      r.hum    = '0;
      r.serial = '0;
      if (first) begin
         rx_phase = PH_HIGH;
         rx_word  = 2'd0;
         rx_crc   = CRC_INIT;
         rx_fail  = 1'b0;
         rx_kind  = (mode == MODE_UNUSED) ? KIND_READY : kind_type'(mode);
      end
      case (rx_phase)
         PH_HIGH: begin
            rx_words[rx_word] = {b, 8'h00};
            rx_crc = crc_next(rx_crc, b);
            rx_phase = PH_LOW;
            return 1'b0;
         end
         PH_LOW: begin
            rx_words[rx_word][7:0] = b;
            rx_crc = crc_next(rx_crc, b);
            rx_phase = PH_CRC;
            return 1'b0;
         end
         default: ;
      endcase
      if (b != rx_crc)
         rx_fail = 1'b1;
      rx_crc   = CRC_INIT;
      rx_phase = PH_HIGH;
      rx_word  = rx_word + 2'd1;
      if (rx_kind != KIND_READY && rx_word < 2'd3)
         return 1'b0;
      r.kind   = rx_kind;
      r.status = rx_fail;
      if (!rx_fail) begin
         case (rx_kind)
            KIND_READY: r.ready = |(rx_words[0] & READY_MASK);
            KIND_MEAS: begin
               t = (int'(TEMP_GAIN) * int'(rx_words[1])) >>> 16;
               h = (int'(HUM_GAIN) * int'(rx_words[2])) >>> 16;
               r.co2  = rx_words[0];
               r.temp = 15'(t - int'(TEMP_OFFSET));
               r.hum  = 14'(h);
            end
            default: r.serial = {rx_words[0], rx_words[1], rx_words[2]};
         endcase
      end
      rx_word = 2'd0;
      rx_fail = 1'b0;
      return 1'b1;
   endfunction

   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0)
         quiet_left = $urandom_range(5, 30);
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // one byte over req_; valid stays high into the next call when no gap is drawn
   task automatic send_byte(input logic [1:0] mode, input logic [7:0] b, input logic first);
      int gap;
      sensor_result_type r;
      gap = draw_wait(send_quiet_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_rx_byte <= b;
      req_first   <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (decode_byte(mode, b, first, r))
         awaited_results.push_back(r);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [1:0] mode, input logic [1:0] later_mode,
                            input logic [15:0] w, input logic first, input bit corrupt);
      logic [23:0] f;
      f = frame_word(w, corrupt);
      send_byte(mode, f[23:16], first);
      send_byte(later_mode, f[15:8], 1'b0);
      send_byte(later_mode, f[7:0], 1'b0);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin : result_sink
      int n;
      sensor_result_type want;
      @(posedge clock);
      forever begin
         n = draw_wait(sink_quiet_left);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (awaited_results.size() == 0) begin
            $error("unexpected word: kind %0d status %0b", rsp_kind, rsp_status);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_kind));
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("data_ready", 64'(want.ready), 64'(rsp_data_ready));
            check_field("co2_ppm", 64'(want.co2), 64'(rsp_co2_ppm));
            check_field("temp_centi", 64'(want.temp), 64'(rsp_temp_centi));
            check_field("humidity_centi", 64'(want.hum), 64'(rsp_humidity_centi));
            check_field("serial_number", 64'(want.serial), 64'(rsp_serial_number));
         end
      end
   end

   // no first mark after reset, then a second response by wrap
   task automatic test_unmarked_start();
      send_word(KIND_MEAS, KIND_SERIAL, 16'hF800, 1'b0, 1'b0);
      send_word(KIND_SERIAL, KIND_MEAS, 16'h0400, 1'b0, 1'b0);
   endtask

   task automatic test_mode_three();
      send_word(MODE_UNUSED, MODE_UNUSED, 16'hFFFF, 1'b1, 1'b1);
   endtask

   // mode on later bytes must be ignored
   task automatic test_measurement_extremes();
      send_word(KIND_MEAS, KIND_SERIAL, 16'hFFFF, 1'b1, 1'b0);
      send_word(KIND_MEAS, KIND_READY, 16'h0000, 1'b0, 1'b0);
      send_word(KIND_MEAS, MODE_UNUSED, 16'hFFFF, 1'b0, 1'b0);
   endtask

   task automatic test_serial_crc_error();
      send_word(KIND_SERIAL, KIND_READY, 16'hFFFF, 1'b1, 1'b0);
      send_word(KIND_SERIAL, KIND_MEAS, 16'h8000, 1'b0, 1'b1);
      send_word(KIND_SERIAL, KIND_SERIAL, 16'h0001, 1'b0, 1'b0);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom) & ~READY_MASK;
         3:       return 16'($urandom_range(1, 2047));
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly whole responses; some cut short, some noise
   task automatic test_random_traffic();
      logic [7:0]  frame [$];
      logic [23:0] f;
      logic [1:0]  mode;
      logic        lead;
      int          start, pick, words, bad, cut;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         pick  = $urandom_range(0, 99);
         mode  = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
         words = (mode == KIND_MEAS || mode == KIND_SERIAL) ? 3 : 1;
         bad   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, words - 1) : -1;
         frame.delete();
         for (int i = 0; i < words; i++) begin
            f = frame_word(pick_word(), i == bad);
            frame.push_back(f[23:16]);
            frame.push_back(f[15:8]);
            frame.push_back(f[7:0]);
         end
         cut  = frame.size();
         lead = ($urandom_range(0, 9) != 0);
         if (pick >= 85) begin
            frame.delete();
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
            cut  = frame.size();
            lead = 1'($urandom);
         end else if (pick >= 72) begin
            cut = $urandom_range(1, frame.size() - 1);
         end
         for (int i = 0; i < cut; i++)
            send_byte(i == 0 ? mode : 2'($urandom), frame[i],
                      i == 0 ? lead : (pick >= 85 ? 1'($urandom) : 1'b0));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_unmarked_start();
      test_mode_three();
      test_measurement_extremes();
      test_serial_crc_error();
      test_random_traffic();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
